### src/lbf_pkg.sv
package lbf_pkg;

	// number of leds and width of an led index
	localparam int LED_N = 3;
	localparam int IDX_W = 2;

	// operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// command codes, codes above init behave as pattern
	localparam logic [2:0] CMD_ALL_OFF = 3'd0;
	localparam logic [2:0] CMD_OFF     = 3'd1;
	localparam logic [2:0] CMD_ON      = 3'd2;
	localparam logic [2:0] CMD_PATTERN = 3'd3;
	localparam logic [2:0] CMD_INIT    = 3'd4;

	// led selection codes
	localparam logic [3:0] SEL_RED       = 4'd0;
	localparam logic [3:0] SEL_GREEN     = 4'd1;
	localparam logic [3:0] SEL_BLUE      = 4'd2;
	localparam logic [3:0] SEL_RED_GREEN = 4'd3;
	localparam logic [3:0] SEL_RED_BLUE  = 4'd4;
	localparam logic [3:0] SEL_GREEN_RED = 4'd5;
	localparam logic [3:0] SEL_GREEN_BLUE = 4'd6;
	localparam logic [3:0] SEL_BLUE_RED  = 4'd7;
	localparam logic [3:0] SEL_BLUE_GREEN = 4'd8;

	// mode word bit positions
	localparam int MODE_BLINK_BIT = 12;
	localparam int MODE_ALT_BIT   = 13;
	localparam int MODE_FLASH_BIT = 14;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_BLINK     = 3'd1,
		KIND_ALT_BLINK = 3'd2,
		KIND_FLASH     = 3'd3,
		KIND_ALT_FLASH = 3'd4
	} kind_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  led_select;
		logic [2:0]  command;
		logic [15:0] mode_word;
	} req_item_t;

	typedef struct packed {
		logic [2:0] led_levels;
		logic [2:0] led_states;
		logic       accepted;
	} rsp_item_t;

	// master of a pair selection
	function automatic logic [IDX_W-1:0] pair_master(input logic [3:0] sel);
		logic [IDX_W-1:0] r;
		unique case (sel)
			SEL_RED_GREEN, SEL_RED_BLUE:   r = 2'd0;
			SEL_GREEN_RED, SEL_GREEN_BLUE: r = 2'd1;
			SEL_BLUE_RED, SEL_BLUE_GREEN:  r = 2'd2;
			default:                       r = sel[IDX_W-1:0];
		endcase
		return r;
	endfunction

	// slave of a pair selection
	function automatic logic [IDX_W-1:0] pair_slave(input logic [3:0] sel);
		logic [IDX_W-1:0] r;
		unique case (sel)
			SEL_GREEN_RED, SEL_BLUE_RED:   r = 2'd0;
			SEL_RED_GREEN, SEL_BLUE_GREEN: r = 2'd1;
			SEL_RED_BLUE, SEL_GREEN_BLUE:  r = 2'd2;
			default:                       r = sel[IDX_W-1:0];
		endcase
		return r;
	endfunction

endpackage

### src/led_blink_flash_pattern_controller_unit.sv
// an accepted item waits in the input stage; its result goes to the result register
// one item per cycle unless stalled; the three leds step in one pass of update logic
// a valid result holds while rsp_stall is high and the input stage stalls behind it
// reset (arst_n low, asynchronous): all leds off and logically off, no pattern running,
// counters, spans, periods and pairings cleared, no item held
module led_blink_flash_pattern_controller_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  lbf_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output lbf_pkg::rsp_item_t  rsp
);

	localparam int N = lbf_pkg::LED_N;
	localparam int W = lbf_pkg::IDX_W;

	// input stage
	logic               valid_s1;
	lbf_pkg::req_item_t item_s1;
	logic               advance;

	// led state
	logic [N-1:0]   lvl_q, on_q, pair_q;
	lbf_pkg::kind_t kind_q [N];
	logic [7:0]     cnt_q [N];
	logic [3:0]     f1_q [N];
	logic [3:0]     f2_q [N];
	logic [7:0]     fp_q [N];
	logic [W-1:0]   ptr_q [N];

	// next led state
	logic [N-1:0]   lvl_n, on_n, pair_n;
	lbf_pkg::kind_t kind_n [N];
	logic [7:0]     cnt_n [N];
	logic [3:0]     f1_n [N];
	logic [3:0]     f2_n [N];
	logic [7:0]     fp_n [N];
	logic [W-1:0]   ptr_n [N];
	logic           ok_n;

	// handshake control
	assign advance   = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
		end
	end

	// input item register
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			item_s1 <= req;
	end

	// update of all leds for the held item
	always_comb begin : upd_blk
		logic [W-1:0] p, m, s;
		logic [7:0]   c;
		logic [4:0]   span2;
		logic         upd, single, paired_sel;
		logic [3:0]   n0, n1, n2;
		logic [15:0]  mode;

		lvl_n  = lvl_q;
		on_n   = on_q;
		pair_n = pair_q;
		kind_n = kind_q;
		cnt_n  = cnt_q;
		f1_n   = f1_q;
		f2_n   = f2_q;
		fp_n   = fp_q;
		ptr_n  = ptr_q;
		ok_n   = 1'b1;
		p      = '0;
		c      = '0;
		span2  = '0;
		upd    = 1'b0;

		mode       = item_s1.mode_word;
		n0         = mode[3:0];
		n1         = mode[7:4];
		n2         = mode[11:8];
		single     = item_s1.led_select < 4'(N);
		paired_sel = item_s1.led_select >= lbf_pkg::SEL_RED_GREEN &&
			item_s1.led_select <= lbf_pkg::SEL_BLUE_GREEN;
		m          = lbf_pkg::pair_master(item_s1.led_select);
		s          = lbf_pkg::pair_slave(item_s1.led_select);

		if (item_s1.operation == lbf_pkg::OP_TICK) begin
			// leds step in index order, each may drive its partner
			for (int i = 0; i < N; i++) begin
				p     = (ptr_q[i] < W'(N)) ? ptr_q[i] : '0;
				c     = cnt_n[i];
				span2 = {1'b0, f1_n[i]} + {1'b0, f2_n[i]};
				upd   = 1'b0;
				unique case (kind_n[i])
					lbf_pkg::KIND_BLINK: begin
						on_n[i]  = !on_n[i];
						lvl_n[i] = on_n[i];
						if (pair_n[i]) begin
							on_n[p]  = !on_n[p];
							lvl_n[p] = on_n[p];
						end
					end
					lbf_pkg::KIND_ALT_BLINK: begin
						if (c < {4'd0, f1_n[i]}) begin
							cnt_n[i] = c + 8'd1;
							if (!on_n[i]) begin
								on_n[i] = 1'b1;
								on_n[p] = 1'b0;
								upd     = 1'b1;
							end
						end else if (c < {3'd0, span2}) begin
							cnt_n[i] = c + 8'd1;
							if (on_n[i]) begin
								on_n[i] = 1'b0;
								if (pair_n[i])
									on_n[p] = 1'b1;
								upd = 1'b1;
							end
						end else begin
							cnt_n[i] = '0;
						end
					end
					lbf_pkg::KIND_FLASH: begin
						if (c < {4'd0, f1_n[i]}) begin
							cnt_n[i] = c + 8'd1;
							if (!on_n[i]) begin
								on_n[i] = 1'b1;
								if (pair_n[i])
									on_n[p] = 1'b1;
								upd = 1'b1;
							end
						end else if (c < fp_n[i]) begin
							cnt_n[i] = c + 8'd1;
							if (pair_n[i]) begin
								if (on_n[p]) begin
									on_n[p] = 1'b0;
									on_n[i] = 1'b0;
									upd     = 1'b1;
								end
							end else if (on_n[i]) begin
								on_n[i] = 1'b0;
								upd     = 1'b1;
							end
						end else begin
							cnt_n[i] = '0;
						end
					end
					lbf_pkg::KIND_ALT_FLASH: begin
						if (c < {4'd0, f1_n[i]}) begin
							cnt_n[i] = c + 8'd1;
							if (!on_n[i]) begin
								on_n[i] = 1'b1;
								if (pair_n[i])
									on_n[p] = 1'b0;
								upd = 1'b1;
							end
						end else if (c < {3'd0, span2}) begin
							cnt_n[i] = c + 8'd1;
							if (on_n[i]) begin
								on_n[i] = 1'b0;
								if (pair_n[i])
									on_n[p] = 1'b1;
								upd = 1'b1;
							end
						end else if (c < fp_n[i]) begin
							cnt_n[i] = c + 8'd1;
							if (pair_n[i]) begin
								if (on_n[p]) begin
									on_n[i] = 1'b0;
									on_n[p] = 1'b0;
									upd     = 1'b1;
								end
							end else begin
								on_n[i] = 1'b0;
								upd     = 1'b1;
							end
						end else begin
							cnt_n[i] = '0;
						end
					end
					default: begin
					end
				endcase
				// drive levels after a pattern change
				if (upd) begin
					lvl_n[i] = on_n[i];
					if (pair_n[i])
						lvl_n[p] = on_n[p];
				end
			end
		end else if (item_s1.command == lbf_pkg::CMD_ALL_OFF) begin
			// clear every led
			for (int i = 0; i < N; i++) begin
				kind_n[i] = lbf_pkg::KIND_NONE;
				on_n[i]   = 1'b0;
				pair_n[i] = 1'b0;
				cnt_n[i]  = '0;
				lvl_n[i]  = 1'b0;
			end
		end else if (item_s1.command == lbf_pkg::CMD_INIT) begin
			ok_n = 1'b1;
		end else if (!single && !paired_sel) begin
			ok_n = 1'b0;
		end else if (item_s1.command == lbf_pkg::CMD_OFF) begin
			// clear master, and slave for a pair
			kind_n[m] = lbf_pkg::KIND_NONE;
			on_n[m]   = 1'b0;
			pair_n[m] = 1'b0;
			cnt_n[m]  = '0;
			lvl_n[m]  = 1'b0;
			if (paired_sel) begin
				kind_n[s] = lbf_pkg::KIND_NONE;
				on_n[s]   = 1'b0;
				pair_n[s] = 1'b0;
				cnt_n[s]  = '0;
				lvl_n[s]  = 1'b0;
			end
		end else if (item_s1.command == lbf_pkg::CMD_ON) begin
			// pair on drives both high but keeps the logical states
			kind_n[m] = lbf_pkg::KIND_NONE;
			lvl_n[m]  = 1'b1;
			if (single)
				on_n[m] = 1'b1;
			else
				lvl_n[s] = 1'b1;
		end else begin
			// pattern start, levels untouched until the first step
			kind_n[m] = lbf_pkg::KIND_NONE;
			on_n[m]   = 1'b0;
			cnt_n[m]  = '0;
			if (single) begin
				pair_n[m] = 1'b0;
				priority if (mode[lbf_pkg::MODE_BLINK_BIT]) begin
					f1_n[m]   = n0;
					f2_n[m]   = '0;
					kind_n[m] = lbf_pkg::KIND_BLINK;
				end else if (mode[lbf_pkg::MODE_ALT_BIT]) begin
					kind_n[m] = lbf_pkg::KIND_NONE;
				end else if (mode[lbf_pkg::MODE_FLASH_BIT]) begin
					f1_n[m]   = n0;
					f2_n[m]   = '0;
					fp_n[m]   = {1'b0, n2, 3'd0} + {3'd0, n2, 1'b0};
					kind_n[m] = lbf_pkg::KIND_FLASH;
				end else begin
					kind_n[m] = lbf_pkg::KIND_NONE;
				end
			end else begin
				on_n[s]   = 1'b0;
				pair_n[m] = 1'b1;
				ptr_n[m]  = s;
				priority if (mode[lbf_pkg::MODE_BLINK_BIT]) begin
					f1_n[m]   = n0;
					f2_n[m]   = '0;
					kind_n[m] = lbf_pkg::KIND_BLINK;
				end else if (mode[lbf_pkg::MODE_ALT_BIT]) begin
					f1_n[m]   = n0;
					f2_n[m]   = n1;
					kind_n[m] = lbf_pkg::KIND_ALT_BLINK;
				end else if (mode[lbf_pkg::MODE_FLASH_BIT]) begin
					f1_n[m]   = n0;
					f2_n[m]   = n1;
					fp_n[m]   = {1'b0, n2, 3'd0} + {3'd0, n2, 1'b0};
					kind_n[m] = lbf_pkg::KIND_ALT_FLASH;
				end else begin
					kind_n[m] = lbf_pkg::KIND_NONE;
				end
			end
		end
	end

	// led state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			on_q   <= '0;
			pair_q <= '0;
			for (int i = 0; i < N; i++) begin
				kind_q[i] <= lbf_pkg::KIND_NONE;
				cnt_q[i]  <= '0;
				f1_q[i]   <= '0;
				f2_q[i]   <= '0;
				fp_q[i]   <= '0;
				ptr_q[i]  <= '0;
			end
		end else if (advance) begin
			lvl_q  <= lvl_n;
			on_q   <= on_n;
			pair_q <= pair_n;
			kind_q <= kind_n;
			cnt_q  <= cnt_n;
			f1_q   <= f1_n;
			f2_q   <= f2_n;
			fp_q   <= fp_n;
			ptr_q  <= ptr_n;
		end
	end

	// result item register
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.led_levels <= lvl_n;
			rsp.led_states <= on_n;
			rsp.accepted   <= ok_n;
		end
	end

endmodule

### test/tb_led_blink_flash_pattern_controller_unit.sv
`timescale 1ns / 100ps

module tb_led_blink_flash_pattern_controller_unit;

	import lbf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 40;

	// selections outside the known set, and command codes that act as pattern
	localparam logic [3:0] SEL_UNKNOWN_LO = 4'd9;
	localparam logic [3:0] SEL_UNKNOWN_HI = 4'd15;
	localparam logic [2:0] CMD_SPARE_LO   = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI   = 3'd7;

	// receiver stall pattern, one bit per cycle
	localparam logic [15:0] STALL_PATTERN = 16'b0110_0011_1000_0101;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN
	} rx_style_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// predicted led state
	logic       led_drv    [LED_N];
	logic       led_on     [LED_N];
	kind_t      led_kind   [LED_N];
	logic [7:0] led_ticks  [LED_N];
	logic [3:0] led_span1  [LED_N];
	logic [3:0] led_span2  [LED_N];
	logic [7:0] led_period [LED_N];
	logic       led_paired [LED_N];
	logic [1:0] led_mate   [LED_N];

	rsp_item_t pending_leds_q[$];
	rsp_item_t want_rsp;

	int        err_count = 0;
	int        items_sent = 0;
	int        burst_left = 1;
	int        cycle_count = 0;
	int        hold_asked = 0;
	int        hold_taken = 0;
	int        hold_left = 0;
	logic [3:0] stall_phase = '0;
	rx_style_t rx_style = RX_FREE;

	led_blink_flash_pattern_controller_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** led_blink_flash_pattern_controller_unit: FAILED **");
			$finish;
		end
	end

	// receiver stall: long hold on request, otherwise the current style
	always @(posedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (hold_taken != hold_asked) begin
			hold_taken <= hold_asked;
			hold_left  <= HOLD_CYCLES;
			rsp_stall  <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_FREE:   rsp_stall <= 1'b0;
				RX_RANDOM: rsp_stall <= ($urandom_range(99) < 35);
				default:   rsp_stall <= STALL_PATTERN[stall_phase];
			endcase
		end
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s got %0h, expected %0h", $time, what, got, want);
	endtask

	// predictor
	function automatic void reset_led_model();
		int i;
		for (i = 0; i < LED_N; i++) begin
			led_drv[i]    = 1'b0;
			led_on[i]     = 1'b0;
			led_kind[i]   = KIND_NONE;
			led_ticks[i]  = '0;
			led_span1[i]  = '0;
			led_span2[i]  = '0;
			led_period[i] = '0;
			led_paired[i] = 1'b0;
			led_mate[i]   = '0;
		end
	endfunction

	function automatic void clear_led_state(input int i);
		led_kind[i]   = KIND_NONE;
		led_on[i]     = 1'b0;
		led_paired[i] = 1'b0;
		led_ticks[i]  = '0;
		led_drv[i]    = 1'b0;
	endfunction

	// one tick of one led's pattern, possibly driving its partner
	function automatic void step_led_pattern(input int i);
		int p, c, f1, f2, fp;
		bit upd;
		p = (led_mate[i] < LED_N) ? int'(led_mate[i]) : 0;
		c = led_ticks[i];
		f1 = led_span1[i];
		f2 = led_span2[i];
		fp = led_period[i];
		upd = 1'b0;
		case (led_kind[i])
			KIND_BLINK: begin
				led_on[i] = ~led_on[i];
				led_drv[i] = led_on[i];
				if (led_paired[i]) begin
					led_on[p] = ~led_on[p];
					led_drv[p] = led_on[p];
				end
			end
			KIND_ALT_BLINK: begin
				if (c < f1) begin
					led_ticks[i] = 8'(c + 1);
					if (!led_on[i]) begin
						led_on[i] = 1'b1;
						led_on[p] = 1'b0;
						upd = 1'b1;
					end
				end else if (c < f1 + f2) begin
					led_ticks[i] = 8'(c + 1);
					if (led_on[i]) begin
						led_on[i] = 1'b0;
						if (led_paired[i])
							led_on[p] = 1'b1;
						upd = 1'b1;
					end
				end else begin
					led_ticks[i] = '0;
				end
			end
			KIND_FLASH: begin
				if (c < f1) begin
					led_ticks[i] = 8'(c + 1);
					if (!led_on[i]) begin
						led_on[i] = 1'b1;
						if (led_paired[i])
							led_on[p] = 1'b1;
						upd = 1'b1;
					end
				end else if (c < fp) begin
					led_ticks[i] = 8'(c + 1);
					if (led_paired[i]) begin
						if (led_on[p]) begin
							led_on[p] = 1'b0;
							led_on[i] = 1'b0;
							upd = 1'b1;
						end
					end else if (led_on[i]) begin
						led_on[i] = 1'b0;
						upd = 1'b1;
					end
				end else begin
					led_ticks[i] = '0;
				end
			end
			KIND_ALT_FLASH: begin
				if (c < f1) begin
					led_ticks[i] = 8'(c + 1);
					if (!led_on[i]) begin
						led_on[i] = 1'b1;
						if (led_paired[i])
							led_on[p] = 1'b0;
						upd = 1'b1;
					end
				end else if (c < f1 + f2) begin
					led_ticks[i] = 8'(c + 1);
					if (led_on[i]) begin
						led_on[i] = 1'b0;
						if (led_paired[i])
							led_on[p] = 1'b1;
						upd = 1'b1;
					end
				end else if (c < fp) begin
					led_ticks[i] = 8'(c + 1);
					if (led_paired[i]) begin
						if (led_on[p]) begin
							led_on[i] = 1'b0;
							led_on[p] = 1'b0;
							upd = 1'b1;
						end
					end else begin
						led_on[i] = 1'b0;
						upd = 1'b1;
					end
				end else begin
					led_ticks[i] = '0;
				end
			end
			default: ;
		endcase
		if (upd) begin
			led_drv[i] = led_on[i];
			if (led_paired[i])
				led_drv[p] = led_on[p];
		end
	endfunction

	// a command item; returns 0 for an unknown selection except all off and init
	function automatic bit apply_led_command(input logic [3:0] sel, input logic [2:0] cmd,
			input logic [15:0] mode);
		int m, s, i;
		bit single, pair;
		single = (sel < LED_N);
		pair = (sel >= SEL_RED_GREEN && sel <= SEL_BLUE_GREEN);
		if (cmd == CMD_ALL_OFF) begin
			for (i = 0; i < LED_N; i++)
				clear_led_state(i);
			return 1'b1;
		end
		if (cmd == CMD_INIT)
			return 1'b1;
		if (!single && !pair)
			return 1'b0;
		m = sel;
		s = sel;
		case (sel)
			SEL_RED_GREEN:  begin m = 0; s = 1; end
			SEL_RED_BLUE:   begin m = 0; s = 2; end
			SEL_GREEN_RED:  begin m = 1; s = 0; end
			SEL_GREEN_BLUE: begin m = 1; s = 2; end
			SEL_BLUE_RED:   begin m = 2; s = 0; end
			SEL_BLUE_GREEN: begin m = 2; s = 1; end
			default: ;
		endcase
		if (cmd == CMD_OFF) begin
			clear_led_state(m);
			if (pair)
				clear_led_state(s);
			return 1'b1;
		end
		// pair on drives both but leaves the logical states alone
		if (cmd == CMD_ON) begin
			led_kind[m] = KIND_NONE;
			if (single)
				led_on[m] = 1'b1;
			led_drv[m] = 1'b1;
			led_drv[s] = 1'b1;
			return 1'b1;
		end
		// pattern, also the spare command codes
		led_kind[m] = KIND_NONE;
		led_on[m] = 1'b0;
		led_ticks[m] = '0;
		if (single) begin
			led_paired[m] = 1'b0;
			if (mode[MODE_BLINK_BIT]) begin
				led_span1[m] = mode[3:0];
				led_span2[m] = '0;
				led_kind[m] = KIND_BLINK;
			end else if (mode[MODE_ALT_BIT]) begin
				// alternate blink needs a pair
			end else if (mode[MODE_FLASH_BIT]) begin
				led_span1[m] = mode[3:0];
				led_span2[m] = '0;
				led_period[m] = 8'(10 * int'(mode[11:8]));
				led_kind[m] = KIND_FLASH;
			end
			return 1'b1;
		end
		led_on[s] = 1'b0;
		led_paired[m] = 1'b1;
		led_mate[m] = 2'(s);
		if (mode[MODE_BLINK_BIT]) begin
			led_span1[m] = mode[3:0];
			led_span2[m] = '0;
			led_kind[m] = KIND_BLINK;
		end else if (mode[MODE_ALT_BIT]) begin
			led_span1[m] = mode[3:0];
			led_span2[m] = mode[7:4];
			led_kind[m] = KIND_ALT_BLINK;
		end else if (mode[MODE_FLASH_BIT]) begin
			led_span1[m] = mode[3:0];
			led_span2[m] = mode[7:4];
			led_period[m] = 8'(10 * int'(mode[11:8]));
			led_kind[m] = KIND_ALT_FLASH;
		end
		return 1'b1;
	endfunction

	function automatic rsp_item_t predict_led_item(input req_item_t it);
		rsp_item_t r;
		bit ok;
		int i;
		ok = 1'b1;
		if (it.operation == OP_TICK) begin
			for (i = 0; i < LED_N; i++)
				step_led_pattern(i);
		end else begin
			ok = apply_led_command(it.led_select, it.command, it.mode_word);
		end
		for (i = 0; i < LED_N; i++) begin
			r.led_levels[i] = led_drv[i];
			r.led_states[i] = led_on[i];
		end
		r.accepted = ok;
		return r;
	endfunction

	// result check, then prediction of the item taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_leds_q.size() == 0) begin
					report_mismatch("result with nothing expected", 16'(rsp), '0);
				end else begin
					want_rsp = pending_leds_q.pop_front();
					if (rsp.led_levels !== want_rsp.led_levels)
						report_mismatch("led_levels", 16'(rsp.led_levels),
							16'(want_rsp.led_levels));
					if (rsp.led_states !== want_rsp.led_states)
						report_mismatch("led_states", 16'(rsp.led_states),
							16'(want_rsp.led_states));
					if (rsp.accepted !== want_rsp.accepted)
						report_mismatch("accepted", 16'(rsp.accepted),
							16'(want_rsp.accepted));
				end
			end
			if (req_valid && !req_stall)
				pending_leds_q.push_back(predict_led_item(req));
		end
	end

	// item builders
	function automatic req_item_t command_item(input logic [3:0] sel, input logic [2:0] cmd,
			input logic [15:0] mode);
		req_item_t it;
		it.operation = OP_CMD;
		it.led_select = sel;
		it.command = cmd;
		it.mode_word = mode;
		return it;
	endfunction

	// tick items carry random junk in the ignored fields
	function automatic req_item_t make_tick();
		req_item_t it;
		it.operation = OP_TICK;
		it.led_select = 4'($urandom);
		it.command = 3'($urandom);
		it.mode_word = 16'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] random_mode_word();
		logic [15:0] m;
		int pick;
		m = 16'($urandom);
		if ($urandom_range(9) != 0) begin
			m[3:0] = 4'($urandom_range(5));
			m[7:4] = 4'($urandom_range(5));
			m[11:8] = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(3));
			pick = $urandom_range(99);
			if (pick < 20)
				m[15:12] = 4'b0001;
			else if (pick < 50)
				m[15:12] = 4'b0010;
			else if (pick < 90)
				m[15:12] = 4'b0100;
			else
				m[15:12] = {1'($urandom), 3'b000};
		end
		return m;
	endfunction

	function automatic req_item_t random_command();
		logic [3:0] sel;
		logic [2:0] cmd;
		int pick;
		sel = ($urandom_range(9) == 0) ? 4'($urandom_range(SEL_UNKNOWN_HI, SEL_UNKNOWN_LO))
				: 4'($urandom_range(SEL_BLUE_GREEN));
		pick = $urandom_range(99);
		if (pick < 50)
			cmd = CMD_PATTERN;
		else if (pick < 60)
			cmd = CMD_ON;
		else if (pick < 70)
			cmd = CMD_OFF;
		else if (pick < 76)
			cmd = CMD_ALL_OFF;
		else if (pick < 82)
			cmd = CMD_INIT;
		else
			cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		return command_item(sel, cmd, random_mode_word());
	endfunction

	// offer one item until it is taken; optional burst gaps afterwards
	task automatic send_led_item(input req_item_t it, input bit gaps);
		int gap;
		req <= it;
		req_valid <= 1'b1;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
		if (gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap = $urandom_range(8, 1);
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end
		end
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_led_item(make_tick(), 1'b0);
	endtask

	// sender idle until every expected result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_leds_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// unknown selections are refused, all off and init ignore the selection
	task automatic test_unknown_selection();
		send_led_item(command_item(SEL_UNKNOWN_LO, CMD_OFF, 16'h0000), 1'b0);
		send_led_item(command_item(SEL_UNKNOWN_HI, CMD_ON, 16'hFFFF), 1'b0);
		send_led_item(command_item(SEL_UNKNOWN_HI, CMD_PATTERN, 16'h1000), 1'b0);
		send_led_item(command_item(SEL_UNKNOWN_HI, CMD_ALL_OFF, 16'hFFFF), 1'b0);
		send_led_item(command_item(SEL_UNKNOWN_LO, CMD_INIT, 16'h0000), 1'b0);
	endtask

	task automatic test_single_on_off();
		send_led_item(command_item(SEL_RED, CMD_ON, 16'h0000), 1'b0);
		send_led_item(command_item(SEL_BLUE, CMD_ON, 16'hFFFF), 1'b0);
		send_led_item(command_item(SEL_RED, CMD_OFF, 16'h0000), 1'b0);
	endtask

	// pair on stops the master pattern only, pair off stops both
	task automatic test_pair_on_off();
		send_led_item(command_item(SEL_GREEN, CMD_PATTERN, 16'h1000), 1'b0);
		send_ticks(1);
		send_led_item(command_item(SEL_GREEN_BLUE, CMD_ON, 16'h0000), 1'b0);
		send_ticks(1);
		send_led_item(command_item(SEL_BLUE_GREEN, CMD_OFF, 16'h0000), 1'b0);
	endtask

	// alternate blink on one led and an empty mode stop it; flash, widest period
	task automatic test_single_patterns();
		send_led_item(command_item(SEL_RED, CMD_PATTERN, 16'h2005), 1'b0);
		send_led_item(command_item(SEL_BLUE, CMD_PATTERN, 16'h8000), 1'b0);
		send_led_item(command_item(SEL_RED, CMD_SPARE_HI, 16'h4F02), 1'b0);
		send_ticks(3);
	endtask

	task automatic test_pair_patterns();
		send_led_item(command_item(SEL_RED_BLUE, CMD_PATTERN, 16'h2012), 1'b0);
		send_ticks(3);
		send_led_item(command_item(SEL_BLUE_GREEN, CMD_SPARE_LO, 16'h4321), 1'b0);
		send_ticks(2);
		send_led_item(command_item(SEL_GREEN_RED, CMD_PATTERN, 16'hFFFF), 1'b0);
		send_led_item(command_item(SEL_RED_GREEN, CMD_PATTERN, 16'h0000), 1'b0);
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		int k;
		rx_style = RX_FREE;
		send_led_item(command_item(SEL_GREEN_RED, CMD_PATTERN, 16'h4132), 1'b0);
		hold_asked++;
		for (k = 0; k < 30; k++)
			send_led_item(make_tick(), 1'b0);
		drain_results();
	endtask

	// pattern starts followed by runs of ticks, with some stray commands
	task automatic test_random_traffic(input int n_items, input rx_style_t style,
			input bit gaps);
		int stop_at, run;
		rx_style = style;
		burst_left = $urandom_range(12, 1);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			send_led_item(random_command(), gaps);
			if ($urandom_range(3) == 0)
				send_led_item(random_command(), gaps);
			run = ($urandom_range(7) == 0) ? $urandom_range(160, 40) : $urandom_range(24, 1);
			repeat (run)
				if (items_sent < stop_at)
					send_led_item(make_tick(), gaps);
		end
		drain_results();
	endtask

	initial begin
		reset_led_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unknown_selection();
		test_single_on_off();
		test_pair_on_off();
		test_single_patterns();
		test_pair_patterns();
		drain_results();
		test_backpressure();
		test_random_traffic(300, RX_FREE, 1'b0);
		test_random_traffic(400, RX_RANDOM, 1'b1);
		test_random_traffic(400, RX_PATTERN, 1'b1);
		test_random_traffic(200, RX_RANDOM, 1'b1);
		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending_leds_q.size() == 0)
			$display("** led_blink_flash_pattern_controller_unit: PASSED **");
		else
			$display("** led_blink_flash_pattern_controller_unit: FAILED **");
		$finish;
	end

endmodule
